// ===== hdl/tdd_pkg.sv =====
// Package for the tile damage detector: sizes, register indexes and field widths.
// Used by tile_damage_detector; depends on nothing else.
`timescale 1ns / 1ps
package tdd_pkg;

  // Pixel and position geometry
  localparam int PIXEL_BITS       = 32;
  localparam int POS_W            = 13;
  localparam int SIZE_W           = 14;
  localparam int TILE_LOG2        = 6;
  localparam int COL_W            = POS_W - TILE_LOG2;
  localparam int MAX_TILE_COLUMNS = 128;
  localparam int SLOT_W           = $clog2(MAX_TILE_COLUMNS);
  localparam int TILE_IDX_W       = 7;
  localparam int SIZE_MAX_PIX     = 8192;

  // Stream payload widths
  localparam int IN_TDATA_W  = 2 * PIXEL_BITS;
  localparam int OUT_TDATA_W = 16;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 2'd0,
    REG_SURFACE_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  // Sizes of zero count as one, sizes beyond the largest frame are capped.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(SIZE_MAX_PIX)) begin
      r = SIZE_W'(SIZE_MAX_PIX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/tile_damage_detector.sv =====
// Top level of the tile damage detector: input register, damage map and result register.
// Depends on tdd_pkg.
`timescale 1ns / 1ps
// Usage
// in_*  : one pixel pair per item in raster order; tdata carries the new pixel in the
//         low word and the previous pixel in the high word, tuser is the no-reference flag.
// out_* : one item per finished 64x64 tile (clipped at the right and bottom edges),
//         sent on the tile's last pixel; tlast marks the final tile of the frame.
// cfg_* : register writes (surface width, surface height). Any write to a known
//         register restarts the frame at pixel (0,0) and clears every column flag;
//         write only while no items are in flight.
// Throughput: one pixel pair per cycle unless a pair that closes a tile waits for the
// output register; set by the read-modify-write of the column flag that the pixel falls in.
// Path: an accepted pair is evaluated from the input register and, if it closes a
// tile, its result is written into the output register.
// Reset: width 1920, height 1080, position (0,0), all flags clear, both registers empty.
// Stalls: the output register holds a result until taken. Pairs that close no tile
// keep flowing; a pair that closes a tile waits in the input register, and the input
// side stops taking items, until the output register is free.
module tile_damage_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tdd_pkg::IN_TDATA_W-1:0]    in_tdata,  // [31:0] new_pixel, [63:32] old_pixel
  input  logic                              in_tuser,  // [0] no_reference
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tdd_pkg::OUT_TDATA_W-1:0]   out_tdata, // [6:0] tile_column, [13:7] tile_row,
                                                       // [14] damaged, [15] zero
  output logic                              out_tlast, // last_tile
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdd_pkg::SIZE_W-1:0]        cfg_data
);
  import tdd_pkg::*;

  // Surface size, stored already clamped
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;

  // Raster position and damage map
  logic [POS_W-1:0]            pix_x_r, pix_x_nxt;
  logic [POS_W-1:0]            pix_y_r, pix_y_nxt;
  logic [MAX_TILE_COLUMNS-1:0] flags_r, flags_nxt;

  // Input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIXEL_BITS-1:0] s1_new_r, s1_old_r;
  logic                  s1_noref_r;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [TILE_IDX_W-1:0] out_col_r, out_row_r;
  logic                  out_dmg_r, out_last_r;

  // Per-pixel evaluation
  logic                 in_acc, cfg_acc, cfg_hit;
  logic [COL_W-1:0]     col;
  logic [COL_W-1:0]     row;
  logic [SLOT_W-1:0]    slot;
  logic [SIZE_W-1:0]    x_inc, y_inc;
  logic                 line_end, frame_end, tile_x_end, tile_y_end;
  logic                 emit, hit, adv, out_free;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_acc && ((cfg_index == REG_SURFACE_WIDTH) ||
                               (cfg_index == REG_SURFACE_HEIGHT));
  assign cfg_ready = 1'b1;

  // Tile geometry of the pixel in the input register
  assign col   = pix_x_r[POS_W-1:TILE_LOG2];
  assign row   = pix_y_r[POS_W-1:TILE_LOG2];
  assign slot  = (32'(col) >= MAX_TILE_COLUMNS) ? SLOT_W'(MAX_TILE_COLUMNS - 1)
                                                 : SLOT_W'(col);
  assign x_inc = SIZE_W'(pix_x_r) + SIZE_W'(1);
  assign y_inc = SIZE_W'(pix_y_r) + SIZE_W'(1);
  assign line_end   = x_inc >= width_r;
  assign frame_end  = y_inc >= height_r;
  assign tile_x_end = line_end  || (x_inc[TILE_LOG2-1:0] == '0);
  assign tile_y_end = frame_end || (y_inc[TILE_LOG2-1:0] == '0);
  assign emit = tile_x_end && tile_y_end;
  assign hit  = s1_noref_r || (s1_new_r != s1_old_r);

  // The pixel moves on unless it closes a tile and the result register is busy
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || adv;

  // Next state of position, flags and size registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    pix_x_nxt  = pix_x_r;
    pix_y_nxt  = pix_y_r;
    flags_nxt  = flags_r;
    if (cfg_hit) begin
      if (cfg_index == REG_SURFACE_WIDTH) begin
        width_nxt = clamp_size(cfg_data);
      end else begin
        height_nxt = clamp_size(cfg_data);
      end
      pix_x_nxt = '0;
      pix_y_nxt = '0;
      flags_nxt = '0;
    end else if (adv) begin
      if (emit) begin
        flags_nxt[slot] = 1'b0;
      end else if (hit) begin
        flags_nxt[slot] = 1'b1;
      end
      if (line_end) begin
        pix_x_nxt = '0;
        pix_y_nxt = frame_end ? '0 : y_inc[POS_W-1:0];
      end else begin
        pix_x_nxt = x_inc[POS_W-1:0];
      end
    end
  end

  // Handshake bookkeeping for both registers
  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      pix_x_r     <= '0;
      pix_y_r     <= '0;
      flags_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      pix_x_r     <= pix_x_nxt;
      pix_y_r     <= pix_y_nxt;
      flags_r     <= flags_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_new_r   <= in_tdata[PIXEL_BITS-1:0];
      s1_old_r   <= in_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
      s1_noref_r <= in_tuser;
    end
    if (adv && emit) begin
      out_col_r  <= TILE_IDX_W'(col);
      out_row_r  <= TILE_IDX_W'(row);
      out_dmg_r  <= flags_r[slot] || hit;
      out_last_r <= line_end && frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dmg_r, out_row_r, out_col_r};
  assign out_tlast  = out_last_r;

  // Checks
  a_pos_in_surface: assert property (@(posedge clk) disable iff (!rst_n)
    (SIZE_W'(pix_x_r) < width_r) && (SIZE_W'(pix_y_r) < height_r))
    else $error("raster position outside the surface");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (pix_x_r == '0) && (pix_y_r == '0) && (flags_r == '0))
    else $error("register write did not restart the frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit && line_end && frame_end) |=> (pix_x_r == '0) && (pix_y_r == '0))
    else $error("position did not wrap after the last tile");

  a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (flags_r[$past(slot)] == 1'b0))
    else $error("column flag not cleared after its tile was reported");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(adv && emit))
    else $error("result register overwritten while stalled");

endmodule

// ===== test/tile_damage_detector_tb.sv =====
// Self-checking testbench for tile_damage_detector: streams pixel pairs, writes the
// surface size registers and checks every tile result against a built-in predictor.
// Depends on tdd_pkg and tile_damage_detector.
`timescale 1ns / 1ps
module tile_damage_detector_tb;
  import tdd_pkg::*;

  localparam int TILE_SIZE      = 1 << TILE_LOG2;
  localparam int IDLE_PCT       = 9;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 650;
  localparam int ONE_PIXEL_RUN  = 40;
  localparam int LARGE_PIXELS   = 130;
  localparam int HOLDOFF_AFTER  = 3;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int CALM_START     = 700;
  localparam int CALM_END       = 1200;
  // About 1100 items in all; even with a result per item and both sides stalling,
  // a correct run stays far below this.
  localparam int LIMIT_CYCLES   = 200000;

  // Indexes beyond the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_B = 2'd3;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [SIZE_W-1:0]     reg_val;
    logic [PIXEL_BITS-1:0] new_pixel;
    logic [PIXEL_BITS-1:0] old_pixel;
    logic                  no_reference;
  } feed_item_t;

  typedef struct {
    logic [TILE_IDX_W-1:0] tile_column;
    logic [TILE_IDX_W-1:0] tile_row;
    logic                  damaged;
    logic                  last_tile;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Stimulus waiting to be sent, and tile results waiting to arrive.
  feed_item_t   frame_feed[$];
  tile_result_t predicted_tiles[$];

  // Predictor state: registers, column flags and raster position.
  logic [SIZE_W-1:0]           surface_w = WIDTH_RESET;
  logic [SIZE_W-1:0]           surface_h = HEIGHT_RESET;
  logic [MAX_TILE_COLUMNS-1:0] column_flags = '0;
  logic [POS_W-1:0]            pos_x = '0;
  logic [POS_W-1:0]            pos_y = '0;

  int cycle_count = 0;
  int items_sent = 0;
  int total_items = 0;
  int tiles_due = 0;
  int tiles_checked = 0;
  int damaged_tiles = 0;
  int pixels_seen = 0;
  int writes_seen = 0;
  int mismatches = 0;
  int quiet_cycles = DRAIN_CYCLES;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  logic calm_window;

  assign calm_window = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

  tile_damage_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // A size of zero counts as one pixel; anything past the largest frame is capped.
  function automatic int effective_size(logic [SIZE_W-1:0] v);
    int r;
    r = v;
    if (r == 0) begin
      r = 1;
    end else if (r > SIZE_MAX_PIX) begin
      r = SIZE_MAX_PIX;
    end
    return r;
  endfunction

  // Any write to a known register restarts the frame; unknown indexes change nothing.
  function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                               logic [SIZE_W-1:0] val);
    if (idx == REG_SURFACE_WIDTH || idx == REG_SURFACE_HEIGHT) begin
      if (idx == REG_SURFACE_WIDTH) begin
        surface_w = val;
      end else begin
        surface_h = val;
      end
      column_flags = '0;
      pos_x = '0;
      pos_y = '0;
    end
  endfunction

  // Marks the pixel's tile column as damaged where needed and, on the tile's last
  // pixel, queues the tile result and clears the flag. Then the position advances.
  function automatic void predict_tile(logic [PIXEL_BITS-1:0] new_px,
                                       logic [PIXEL_BITS-1:0] old_px, logic no_ref);
    int w, h, x, y, col, row, slot;
    bit line_end, frame_end, tile_x_end, tile_y_end;
    tile_result_t r;
    w = effective_size(surface_w);
    h = effective_size(surface_h);
    x = pos_x;
    y = pos_y;
    col = x / TILE_SIZE;
    row = y / TILE_SIZE;
    slot = (col < MAX_TILE_COLUMNS) ? col : MAX_TILE_COLUMNS - 1;
    line_end = (x + 1) >= w;
    frame_end = (y + 1) >= h;
    tile_x_end = line_end || ((x + 1) % TILE_SIZE) == 0;
    tile_y_end = frame_end || ((y + 1) % TILE_SIZE) == 0;
    if (no_ref || new_px != old_px) begin
      column_flags[slot] = 1'b1;
    end
    if (tile_x_end && tile_y_end) begin
      r.tile_column = col[TILE_IDX_W-1:0];
      r.tile_row = row[TILE_IDX_W-1:0];
      r.damaged = column_flags[slot];
      r.last_tile = line_end && frame_end;
      predicted_tiles.push_back(r);
      column_flags[slot] = 1'b0;
    end
    if (line_end) begin
      pos_x = '0;
      pos_y = frame_end ? '0 : POS_W'(y + 1);
    end else begin
      pos_x = POS_W'(x + 1);
    end
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_pixel(logic [PIXEL_BITS-1:0] new_px, logic [PIXEL_BITS-1:0] old_px,
                           logic no_ref);
    feed_item_t it;
    it = '{default: '0};
    it.new_pixel = new_px;
    it.old_pixel = old_px;
    it.no_reference = no_ref;
    frame_feed.push_back(it);
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    feed_item_t it;
    it = '{default: '0};
    it.is_write = 1'b1;
    it.reg_idx = idx;
    it.reg_val = val;
    frame_feed.push_back(it);
  endtask

  // A random pair that differs in about rate_pct of a hundred items, either in one
  // bit or throughout; the no-reference flag is set now and then.
  task automatic add_random_pixel(int rate_pct);
    logic [PIXEL_BITS-1:0] old_px, new_px;
    old_px = $urandom;
    new_px = old_px;
    if ($urandom_range(99) < rate_pct) begin
      if ($urandom_range(1) == 0) begin
        new_px = old_px ^ (PIXEL_BITS'(1) << $urandom_range(PIXEL_BITS - 1));
      end else begin
        new_px = $urandom;
      end
    end
    add_pixel(new_px, old_px, $urandom_range(99) < 2);
  endtask

  // Sender: offers items from the feed, idling now and then. A register write waits
  // until every predicted tile has arrived and no pixel has gone in for a while.
  always @(posedge clk) begin
    feed_item_t nxt;
    logic in_busy, cfg_busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_busy = in_tvalid && !in_tready;
      cfg_busy = cfg_valid && !cfg_ready;
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
      end else if (quiet_cycles < DRAIN_CYCLES) begin
        quiet_cycles++;
      end
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready)) begin
        items_sent <= items_sent + 1;
      end
      if (!in_busy && !cfg_busy && frame_feed.size() != 0) begin
        if (frame_feed[0].is_write) begin
          if (tiles_due == 0 && quiet_cycles >= DRAIN_CYCLES) begin
            nxt = frame_feed.pop_front();
            cfg_index <= nxt.reg_idx;
            cfg_data <= nxt.reg_val;
            cfg_busy = 1'b1;
          end
        end else if (calm_window || $urandom_range(99) >= IDLE_PCT) begin
          nxt = frame_feed.pop_front();
          in_tdata <= {nxt.old_pixel, nxt.new_pixel};
          in_tuser <= nxt.no_reference;
          in_busy = 1'b1;
        end
      end
      in_tvalid <= in_busy;
      cfg_valid <= cfg_busy;
    end
  end

  // Receiver: random stalls, plus one long hold-off once results are flowing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!holdoff_done && tiles_checked >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm_window || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: checks each tile result against the oldest prediction, then follows
  // the register writes and pixel items taken at this edge.
  always @(posedge clk) begin
    tile_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (predicted_tiles.size() == 0) begin
          $display("%0t ns: unexpected tile, expected none, got column %0d row %0d",
                   $time, out_tdata[6:0], out_tdata[13:7]);
          mismatches++;
        end else begin
          want = predicted_tiles.pop_front();
          check_field("tile_column", 16'(want.tile_column), 16'(out_tdata[6:0]));
          check_field("tile_row", 16'(want.tile_row), 16'(out_tdata[13:7]));
          check_field("damaged", 16'(want.damaged), 16'(out_tdata[14]));
          check_field("last_tile", 16'(want.last_tile), 16'(out_tlast));
          if (want.damaged) begin
            damaged_tiles++;
          end
        end
        tiles_checked <= tiles_checked + 1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register_write(cfg_index, cfg_data);
        writes_seen++;
      end
      if (in_tvalid && in_tready) begin
        predict_tile(in_tdata[PIXEL_BITS-1:0], in_tdata[2*PIXEL_BITS-1:PIXEL_BITS], in_tuser);
        pixels_seen++;
      end
      tiles_due <= predicted_tiles.size();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int random_pixels, plan_w, plan_h, n, rate, v;

    // Pixels at the reset size close no tile; the writes then restart the frame.
    add_pixel('0, '0, 1'b0);
    add_pixel('1, '0, 1'b0);
    add_pixel('0, '0, 1'b1);
    add_write(REG_SURFACE_WIDTH, '0);
    add_write(REG_SURFACE_HEIGHT, '0);

    // A 1x1 surface: every pixel is a whole tile and the last of its frame.
    add_pixel('0, '0, 1'b0);
    add_pixel('1, '1, 1'b0);
    add_pixel('1, '0, 1'b0);
    add_pixel('0, '1, 1'b0);
    add_pixel(32'h0000_0001, '0, 1'b0);
    add_pixel(32'h8000_0000, '0, 1'b0);
    add_pixel(32'h1234_5678, 32'h1234_5678, 1'b1);
    // The long receiver hold-off starts after the third tile result, so these pixels fill
    // both registers and hold the input back while the sender keeps offering.
    repeat (ONE_PIXEL_RUN) add_random_pixel(50);

    // 3x2 surface with writes to unused indexes in mid-frame, which must not restart it.
    add_write(REG_SURFACE_WIDTH, SIZE_W'(3));
    add_write(REG_SURFACE_HEIGHT, SIZE_W'(2));
    add_pixel(32'h5, 32'h5, 1'b0);
    add_pixel(32'h6, 32'h6, 1'b0);
    add_write(UNMAPPED_REG_A, SIZE_W'(1));
    add_pixel(32'h7, 32'h7, 1'b0);
    add_pixel(32'h8, 32'h9, 1'b0);
    add_pixel(32'h1, 32'h1, 1'b0);
    add_pixel(32'h2, 32'h2, 1'b0);
    add_write(UNMAPPED_REG_B, '1);
    add_pixel('0, '0, 1'b0);
    add_pixel('0, '0, 1'b0);
    add_pixel('0, '0, 1'b0);

    // Random phases: mostly small surfaces so that tiles close often, with sizes
    // around the tile edge and now and then a clamped one.
    plan_w = 3;
    plan_h = 2;
    random_pixels = 0;
    while (random_pixels < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0, 1, 2, 3: v = $urandom_range(16, 1);
          4, 5:       v = $urandom_range(140, 17);
          6:          v = 63 + $urandom_range(2);
          7:          v = 128 + $urandom_range(1);
          8:          v = $urandom_range(4, 1);
          default:    v = ($urandom_range(1) == 0) ? 0 : 8192 + $urandom_range(8191);
        endcase
        add_write(REG_SURFACE_WIDTH, SIZE_W'(v));
        plan_w = effective_size(SIZE_W'(v));
      end
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: v = $urandom_range(6, 1);
          6, 7:             v = $urandom_range(20, 7);
          8:                v = 63 + $urandom_range(2);
          default:          v = $urandom_range(1);
        endcase
        add_write(REG_SURFACE_HEIGHT, SIZE_W'(v));
        plan_h = effective_size(SIZE_W'(v));
      end
      if ($urandom_range(99) < 10) begin
        add_write(($urandom_range(1) == 0) ? UNMAPPED_REG_A : UNMAPPED_REG_B, SIZE_W'($urandom));
      end
      case ($urandom_range(4))
        0:       rate = 0;
        1:       rate = 1;
        2:       rate = 5;
        3:       rate = 25;
        default: rate = 100;
      endcase
      n = plan_w * plan_h * $urandom_range(2, 1) + $urandom_range(plan_w);
      if (n > 240) begin
        n = 240;
      end
      repeat (n) add_random_pixel(rate);
      random_pixels += n;
    end

    // Largest sizes, reached through values above the cap: the start of one
    // full-width line, then the start of one full-height column.
    add_write(REG_SURFACE_WIDTH, SIZE_W'(8193));
    add_write(REG_SURFACE_HEIGHT, SIZE_W'(1));
    repeat (LARGE_PIXELS) add_random_pixel(1);
    add_write(REG_SURFACE_WIDTH, SIZE_W'(1));
    add_write(REG_SURFACE_HEIGHT, '1);
    repeat (LARGE_PIXELS) add_random_pixel(1);

    total_items = frame_feed.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent != total_items) @(posedge clk);
    while (tiles_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixel pairs and %0d register writes (sizes from 1 to 8192).",
             pixels_seen, writes_seen);
    $display("Checked %0d tile results, %0d of them damaged.", tiles_checked, damaged_tiles);
    if (predicted_tiles.size() != 0) begin
      $display("%0t ns: %0d predicted tiles never arrived", $time, predicted_tiles.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
